FILE: rtl/core/integer_alu_with_compare_unit_defines.svh
// Assertion macros used by the ALU top level.
// No dependencies.
`ifndef INTEGER_ALU_WITH_COMPARE_UNIT_DEFINES_SVH
`define INTEGER_ALU_WITH_COMPARE_UNIT_DEFINES_SVH

// Implication checked on every rising clock edge outside reset.
`define IAC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent.
`define IAC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/iac_pkg.sv
// Package for the integer ALU: opcodes.
// No dependencies.
package iac_pkg;
    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MOD = 4'd4;
    localparam logic [3:0] OP_INC = 4'd5;
    localparam logic [3:0] OP_DEC = 4'd6;
    localparam logic [3:0] OP_NOT = 4'd7;
    localparam logic [3:0] OP_SHL = 4'd8;
    localparam logic [3:0] OP_SHR = 4'd9;
    localparam logic [3:0] OP_AND = 4'd10;
    localparam logic [3:0] OP_OR  = 4'd11;
    localparam logic [3:0] OP_XOR = 4'd12;
    localparam logic [3:0] OP_CMP = 4'd13;
    localparam logic [3:0] OP_EQ  = 4'd14;
endpackage

FILE: rtl/core/iac_if.sv
// Valid/ready channel interfaces for the integer ALU.
// Depends on nothing.
interface iac_in_if;
    logic        valid;
    logic        ready;
    logic [3:0]  cmd;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
    logic        b_present;
    modport source (output valid, cmd, operand_a, operand_b, b_present, input ready);
    modport sink   (input valid, cmd, operand_a, operand_b, b_present, output ready);
endinterface

interface iac_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] result;
    logic        div_zero;
    modport source (output valid, result, div_zero, input ready);
    modport sink   (input valid, result, div_zero, output ready);
endinterface

FILE: rtl/core/iac_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// Depends on nothing; stalls via i_en shared with the main pipeline.
module iac_div #(
    parameter int W = 64,
    parameter int TW = 4
) (
    input  logic          i_clk,
    input  logic          i_en,
    input  logic [W-1:0]  i_num,
    input  logic [W-1:0]  i_den,
    input  logic [TW-1:0] i_tag,
    output logic [W-1:0]  o_quo,
    output logic [W-1:0]  o_rem,
    output logic [TW-1:0] o_tag
);
    logic [W-1:0]  r_num [W];
    logic [W-1:0]  r_den [W];
    logic [W-1:0]  r_rem [W];
    logic [TW-1:0] r_tag [W];

    genvar g;
    generate
        for (g = 0; g < W; g++) begin : g_st
            logic [W-1:0]  w_num;
            logic [W-1:0]  w_den;
            logic [W-1:0]  w_rem;
            logic [TW-1:0] w_tag;
            logic [W:0]    n_trial;
            logic [W-1:0]  n_rem;
            logic [W-1:0]  n_num;
            if (g == 0) begin : g_src
                assign w_num = i_num;
                assign w_den = i_den;
                assign w_rem = '0;
                assign w_tag = i_tag;
            end else begin : g_src
                assign w_num = r_num[g-1];
                assign w_den = r_den[g-1];
                assign w_rem = r_rem[g-1];
                assign w_tag = r_tag[g-1];
            end
            always_comb begin
                n_trial = {w_rem, w_num[W-1]} - {1'b0, w_den};
                if (n_trial[W]) begin
                    n_rem = {w_rem[W-2:0], w_num[W-1]};
                    n_num = {w_num[W-2:0], 1'b0};
                end else begin
                    n_rem = n_trial[W-1:0];
                    n_num = {w_num[W-2:0], 1'b1};
                end
            end
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[g] <= n_rem;
                    r_num[g] <= n_num;
                    r_den[g] <= w_den;
                    r_tag[g] <= w_tag;
                end
            end
        end
    endgenerate

    assign o_quo = r_num[W-1];
    assign o_rem = r_rem[W-1];
    assign o_tag = r_tag[W-1];
endmodule

FILE: rtl/core/integer_alu_with_compare_unit.sv
// Top level of the 64-bit integer ALU with compare.
// Depends on iac_pkg, iac_if, iac_div and the defines header.
//
//  channel  | dir | payload
//  s_in     | in  | cmd, operand_a, operand_b, b_present
//  m_out    | out | result, div_zero
//
// One item per cycle while the output is not stalled. DATA_WIDTH+2 register stages:
// operand stage, one divider stage per quotient bit, output stage. Every opcode
// travels a path of the same depth.
// Reset clears the valid bits only. The whole pipeline advances when the
// output stage is empty or taken; a stall freezes every stage in place.
`include "integer_alu_with_compare_unit_defines.svh"
module integer_alu_with_compare_unit #(
    parameter int DATA_WIDTH = 64
) (
    input logic i_clk,
    input logic i_rst_n,
    iac_in_if.sink    s_in,
    iac_out_if.source m_out
);
    localparam int W = DATA_WIDTH;
    localparam int DEPTH = W + 2;
    localparam int H = (W + 1) / 2;

    logic w_en;
    logic [DEPTH-1:0] r_vld;
    assign w_en = !m_out.valid || m_out.ready;
    assign s_in.ready = w_en;

    // stage 0: operand prep
    logic [W-1:0] a0, b0, ua0, ub0;
    logic an0, bn0;
    always_comb begin
        a0  = s_in.operand_a[W-1:0];
        b0  = s_in.b_present ? s_in.operand_b[W-1:0] : '0;
        an0 = a0[W-1];
        bn0 = b0[W-1];
        ua0 = an0 ? -a0 : a0;
        ub0 = bn0 ? -b0 : b0;
    end

    logic [3:0]   r1_cmd;
    logic [W-1:0] r1_a, r1_b, r1_ua, r1_ub;
    logic         r1_hb, r1_an, r1_bn;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_cmd <= s_in.cmd; r1_a <= a0; r1_b <= b0; r1_hb <= s_in.b_present;
            r1_ua <= ua0; r1_ub <= ub0; r1_an <= an0; r1_bn <= bn0;
        end
    end

    // stage 1: simple ops and partial products
    logic [W-1:0]   n_simple;
    logic [5:0]     sh;
    logic [H-1:0]   lo_a, lo_b, hi_a, hi_b;
    logic [2*H-1:0] n_pll, n_plh, n_phl;
    always_comb begin
        sh = r1_b[5:0];
        n_simple = '0;
        unique case (r1_cmd)
            iac_pkg::OP_ADD: n_simple = r1_a + r1_b;
            iac_pkg::OP_SUB: n_simple = r1_a - r1_b;
            iac_pkg::OP_INC: n_simple = r1_a + W'(1);
            iac_pkg::OP_DEC: n_simple = r1_a - W'(1);
            iac_pkg::OP_NOT: n_simple = ~r1_a;
            iac_pkg::OP_SHL: n_simple = !r1_hb ? r1_a :
                (32'(sh) >= W) ? '0 : (r1_a << sh);
            iac_pkg::OP_SHR: n_simple = !r1_hb ? r1_a :
                (32'(sh) >= W) ? {W{r1_a[W-1]}} : W'($signed(r1_a) >>> sh);
            iac_pkg::OP_AND: n_simple = r1_a & r1_b;
            iac_pkg::OP_OR:  n_simple = r1_a | r1_b;
            iac_pkg::OP_XOR: n_simple = r1_a ^ r1_b;
            iac_pkg::OP_CMP: n_simple = ($signed(r1_a) < $signed(r1_b)) ? W'(1) :
                ($signed(r1_b) < $signed(r1_a)) ? '1 : '0;
            iac_pkg::OP_EQ:  n_simple = (r1_a == r1_b) ? W'(1) : '0;
            default:         n_simple = '0;
        endcase
        lo_a = r1_a[H-1:0];
        lo_b = r1_b[H-1:0];
        hi_a = H'(r1_a >> H);
        hi_b = H'(r1_b >> H);
        n_pll = lo_a * lo_b;
        n_plh = lo_a * hi_b;
        n_phl = hi_a * lo_b;
    end

    logic [W-1:0] r2_pll, r2_plh, r2_phl;
    logic [W-1:0] r2_simple;
    logic         r2_cmd_mul, r2_hb;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r2_pll <= W'(n_pll);
            r2_plh <= W'(n_plh);
            r2_phl <= W'(n_phl);
            r2_simple <= n_simple;
            r2_cmd_mul <= (r1_cmd == iac_pkg::OP_MUL);
            r2_hb <= r1_hb;
        end
    end
    logic [W-1:0] w_prod;
    assign w_prod = r2_pll + ((r2_plh + r2_phl) << H);

    // divider runs in parallel; result delay line matches its depth
    localparam int TW = 7;
    logic [TW-1:0] w_tag_in, w_tag_out;
    logic [W-1:0]  w_quo, w_rem;
    assign w_tag_in = {r1_cmd, r1_an, r1_bn, (r1_ub == '0)};
    iac_div #(.W(W), .TW(TW)) u_div (
        .i_clk(i_clk), .i_en(w_en), .i_num(r1_ua), .i_den(r1_ub),
        .i_tag(w_tag_in), .o_quo(w_quo), .o_rem(w_rem), .o_tag(w_tag_out)
    );

    // product/simple delay: stage 2 picks, then W-1 more stages
    logic [W-1:0] n_mid;
    assign n_mid = r2_cmd_mul ? (r2_hb ? w_prod : '0) : r2_simple;
    logic [W-1:0] r_pipe [W-1];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pipe[0] <= n_mid;
            for (int k = 1; k < W - 1; k++) r_pipe[k] <= r_pipe[k-1];
        end
    end

    // final stage: select divider or passed result
    logic [3:0]   f_cmd;
    logic         f_an, f_bn, f_dz;
    logic [W-1:0] n_res;
    logic         n_dz;
    always_comb begin
        f_cmd = w_tag_out[6:3];
        f_an  = w_tag_out[2];
        f_bn  = w_tag_out[1];
        f_dz  = w_tag_out[0];
        n_dz  = 1'b0;
        n_res = r_pipe[W-2];
        if (f_cmd == iac_pkg::OP_DIV || f_cmd == iac_pkg::OP_MOD) begin
            n_dz = f_dz;
            if (f_dz) n_res = '0;
            else if (f_cmd == iac_pkg::OP_DIV) n_res = (f_an != f_bn) ? -w_quo : w_quo;
            else n_res = f_an ? -w_rem : w_rem;
        end
    end

    logic [W-1:0] r_res;
    logic         r_dz;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_res <= n_res;
            r_dz  <= n_dz;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (w_en) r_vld <= {r_vld[DEPTH-2:0], s_in.valid};
    end

    assign m_out.valid    = r_vld[DEPTH-1];
    assign m_out.result   = 64'($signed(r_res));
    assign m_out.div_zero = r_dz;

    logic w_hold, w_dz_out;
    assign w_hold   = m_out.valid && !m_out.ready;
    assign w_dz_out = m_out.valid && r_dz;

    `IAC_ASSERT_IMP(a_dz_zero, i_clk, i_rst_n, w_dz_out, r_res == '0, "div_zero with result")
    `IAC_ASSERT_NXT(a_hold_vld, i_clk, i_rst_n, w_hold, m_out.valid, "held item dropped")
    `IAC_ASSERT_NXT(a_hold_res, i_clk, i_rst_n, w_hold, $stable(r_res), "held item changed")
    `IAC_ASSERT_IMP(a_rdy, i_clk, i_rst_n, !m_out.valid, s_in.ready, "not ready while empty")
endmodule
